[rtl/core/rphs_pkg.sv]
`default_nettype none
package rphs_pkg;

  localparam int unsigned AddrHalfW = 64;
  localparam int unsigned FoldW     = 32;
  localparam int unsigned HashW     = 31;
  localparam int unsigned PrioW     = 8;
  localparam int unsigned MaskLenW  = 8;

  localparam logic [FoldW-1:0]    HashMul       = 32'd1103515245;
  localparam logic [FoldW-1:0]    HashAdd       = 32'd12345;
  localparam logic [MaskLenW-1:0] MaskLenReset  = 8'd126;
  localparam logic [MaskLenW-1:0] MaskLenFull   = 8'd128;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_XOR,
    ST_MUL2,
    ST_CMP,
    ST_EMIT
  } rphs_state_e;

  typedef struct packed {
    logic ld_mul1;
    logic ld_xor;
    logic ld_mul2;
  } rphs_hash_ctrl_t;

  // Folds a 128-bit address to 32 bits, each word read little-endian.
  function automatic logic [FoldW-1:0] fold_addr(input logic [AddrHalfW-1:0] hi,
                                                 input logic [AddrHalfW-1:0] lo);
    logic [FoldW-1:0] be;
    be = hi[63:32] ^ hi[31:0] ^ lo[63:32] ^ lo[31:0];
    return {be[7:0], be[15:8], be[23:16], be[31:24]};
  endfunction

endpackage
`default_nettype wire

[rtl/core/rphs_group_mask.sv]
`default_nettype none
module rphs_group_mask (
  input  logic [rphs_pkg::MaskLenW-1:0]  mask_len_i,
  input  logic [rphs_pkg::AddrHalfW-1:0] group_hi_i,
  input  logic [rphs_pkg::AddrHalfW-1:0] group_lo_i,
  output logic [rphs_pkg::FoldW-1:0]     group_fold_o
);
  import rphs_pkg::*;

  logic [MaskLenW-1:0]  len_sat;
  logic [6:0]           n_hi;
  logic [6:0]           n_lo;
  logic [AddrHalfW-1:0] keep_hi;
  logic [AddrHalfW-1:0] keep_lo;

  always_comb begin
    len_sat = (mask_len_i > MaskLenFull) ? MaskLenFull : mask_len_i;
    if (len_sat > 8'd64) begin
      n_hi = 7'd64;
      n_lo = 7'(len_sat - 8'd64);
    end else begin
      n_hi = len_sat[6:0];
      n_lo = 7'd0;
    end
    keep_hi = ~({AddrHalfW{1'b1}} >> n_hi);
    keep_lo = ~({AddrHalfW{1'b1}} >> n_lo);
    group_fold_o = fold_addr(group_hi_i & keep_hi, group_lo_i & keep_lo);
  end

endmodule
`default_nettype wire

[rtl/core/rphs_hash_unit.sv]
`default_nettype none
module rphs_hash_unit (
  input  logic                             clk_i,
  input  rphs_pkg::rphs_hash_ctrl_t        ctrl_i,
  input  logic [rphs_pkg::FoldW-1:0]       group_fold_i,
  input  logic [rphs_pkg::FoldW-1:0]       cand_fold_i,
  output logic [rphs_pkg::HashW-1:0]       hash_o
);
  import rphs_pkg::*;

  logic [FoldW-1:0]   mul_q, mul_d;
  logic [FoldW-1:0]   x_q, x_d;
  logic [FoldW-1:0]   mul_a;
  logic [2*FoldW-1:0] product;
  logic [FoldW-1:0]   sum;

  // The single multiplier serves both rounds of the hash.
  always_comb begin
    mul_a   = ctrl_i.ld_mul2 ? x_q : group_fold_i;
    product = mul_a * HashMul;
    sum     = mul_q + HashAdd;
    mul_d   = (ctrl_i.ld_mul1 || ctrl_i.ld_mul2) ? product[FoldW-1:0] : mul_q;
    x_d     = ctrl_i.ld_xor ? (sum ^ cand_fold_i) : x_q;
    hash_o  = sum[HashW-1:0];
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    x_q   <= x_d;
  end

endmodule
`default_nettype wire

[rtl/core/rp_hash_selection_top.sv]
`default_nettype none
// Rendezvous point selection by the PIM hash function.
// Candidates enter on the s_axis channel, one transfer each, sorted by
// ascending priority value. tuser marks the first candidate of a lookup,
// which also carries the group address; tlast marks the last candidate.
// The hash mask length is written through cfg_we_i / cfg_wdata_i; the user
// writes it only while the block is idle, which the block itself does not enforce; it resets to 126.
// Each transfer with tlast produces one result transfer on m_axis with the
// chosen address, its priority and its 31-bit hash.
// A candidate that is hashed passes through these steps before the next ready:
// a multiply, the XOR with the candidate's fold, a second
// multiply through the same 32x32 multiplier, the compare, the output load
// and the idle cycle that raises ready again. A candidate that is skipped
// for its priority goes from its transfer straight to the output load. The
// result register is loaded at the output load of a last candidate, hashed or skipped.
// The result register lets the next candidates enter while a result waits;
// a new result is held back while the receiver stalls with the previous one
// still pending. Reset clears the selection state and empties the result
// register.
module rp_hash_selection_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // group_addr_hi, group_addr_lo, rp_addr_hi, rp_addr_lo, rp_priority
  input  logic [263:0] s_axis_tdata_i,
  // first_candidate
  input  logic         s_axis_tuser_i,
  // last_candidate
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // chosen_rp_hi, chosen_rp_lo, chosen_priority, winning_hash, zero pad
  output logic [167:0] m_axis_tdata_o
);
  import rphs_pkg::*;

  rphs_state_e          state_q, state_d;
  logic [MaskLenW-1:0]  mask_len_q;
  logic [FoldW-1:0]     group_fold_q;
  logic [FoldW-1:0]     group_fold_new;
  logic [FoldW-1:0]     cand_fold_q;
  logic [AddrHalfW-1:0] rp_hi_q, rp_lo_q;
  logic [PrioW-1:0]     rp_prio_q;
  logic                 first_q, last_q;
  logic                 closed_q;
  logic [HashW-1:0]     best_hash_q;
  logic [AddrHalfW-1:0] best_hi_q, best_lo_q;
  logic [PrioW-1:0]     best_prio_q;
  logic                 out_valid_q;
  logic [AddrHalfW-1:0] out_hi_q, out_lo_q;
  logic [PrioW-1:0]     out_prio_q;
  logic [HashW-1:0]     out_hash_q;

  logic                 in_fire;
  logic                 in_first;
  logic [PrioW-1:0]     in_prio;
  logic                 do_hash;
  logic                 out_load;
  logic                 take_new;
  logic [HashW-1:0]     hash;
  rphs_hash_ctrl_t      hctrl;

  assign in_first = s_axis_tuser_i;
  assign in_prio  = s_axis_tdata_i[263:256];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign do_hash  = in_first || (!closed_q && (in_prio == best_prio_q));

  rphs_group_mask u_group_mask (
    .mask_len_i   (mask_len_q),
    .group_hi_i   (s_axis_tdata_i[63:0]),
    .group_lo_i   (s_axis_tdata_i[127:64]),
    .group_fold_o (group_fold_new)
  );

  rphs_hash_unit u_hash_unit (
    .clk_i        (clk_i),
    .ctrl_i       (hctrl),
    .group_fold_i (group_fold_q),
    .cand_fold_i  (cand_fold_q),
    .hash_o       (hash)
  );

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    hctrl           = '0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = do_hash ? ST_MUL1 : ST_EMIT;
        end
      end
      ST_MUL1: begin
        hctrl.ld_mul1 = 1'b1;
        state_d       = ST_XOR;
      end
      ST_XOR: begin
        hctrl.ld_xor = 1'b1;
        state_d      = ST_MUL2;
      end
      ST_MUL2: begin
        hctrl.ld_mul2 = 1'b1;
        state_d       = ST_CMP;
      end
      ST_CMP: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_len_q <= MaskLenReset;
    end else if (cfg_we_i) begin
      mask_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rp_hi_q     <= s_axis_tdata_i[191:128];
      rp_lo_q     <= s_axis_tdata_i[255:192];
      rp_prio_q   <= in_prio;
      first_q     <= in_first;
      last_q      <= s_axis_tlast_i;
      cand_fold_q <= fold_addr(s_axis_tdata_i[191:128], s_axis_tdata_i[255:192]);
    end
  end

  always_comb begin
    take_new = first_q || (hash > best_hash_q) ||
               ((hash == best_hash_q) && ({rp_hi_q, rp_lo_q} > {best_hi_q, best_lo_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_fold_q <= '0;
      closed_q     <= 1'b0;
      best_hash_q  <= '0;
      best_hi_q    <= '0;
      best_lo_q    <= '0;
      best_prio_q  <= '0;
    end else begin
      if (in_fire) begin
        if (in_first) begin
          group_fold_q <= group_fold_new;
          closed_q     <= 1'b0;
        end else if (!closed_q && (in_prio != best_prio_q)) begin
          closed_q <= 1'b1;
        end
      end
      if (state_q == ST_CMP && take_new) begin
        best_hash_q <= hash;
        best_hi_q   <= rp_hi_q;
        best_lo_q   <= rp_lo_q;
        if (first_q) begin
          best_prio_q <= rp_prio_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hi_q   <= best_hi_q;
      out_lo_q   <= best_lo_q;
      out_prio_q <= best_prio_q;
      out_hash_q <= best_hash_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_hash_q, out_prio_q, out_lo_q, out_hi_q};

endmodule
`default_nettype wire

[verif/rp_hash_selection_top_tb.sv]
`timescale 1ns / 100ps

module rp_hash_selection_top_tb;
  import rphs_pkg::*;

  localparam int unsigned IdleLimit    = 5000;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned PhaseItems   = 60;
  localparam int unsigned NumRows      = 20;
  localparam int unsigned NumMasks     = 10;

  localparam logic [63:0] AllOnes = {64{1'b1}};
  localparam logic [63:0] GrpHi   = 64'hFF3E_0000_0000_0000;
  localparam logic [63:0] GrpLo   = 64'h0000_0000_0000_1234;

  typedef struct packed {
    logic [63:0] g_hi;
    logic [63:0] g_lo;
    logic [63:0] r_hi;
    logic [63:0] r_lo;
    logic [7:0]  prio;
    logic        is_first;
    logic        is_last;
  } cand_t;

  typedef struct packed {
    logic [63:0] rp_hi;
    logic [63:0] rp_lo;
    logic [7:0]  prio;
    logic [30:0] hash;
  } pick_t;

  typedef enum logic {
    CHK_PREDICT,
    CHK_FIXED
  } chk_e;

  typedef struct packed {
    cand_t cand;
    chk_e  chk;
    pick_t fixed;
  } stim_row_t;

  localparam pick_t NoPick = '0;

  logic         clk_i = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [7:0]   cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [263:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;

  rp_hash_selection_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Selection state of the lookup in progress, as the block should hold it.
  logic [7:0]  sel_mask_len = MaskLenReset;
  logic [31:0] sel_grp_fold = '0;
  logic [30:0] sel_hash = '0;
  logic [63:0] sel_hi = '0;
  logic [63:0] sel_lo = '0;
  logic [7:0]  sel_prio = '0;
  bit          sel_closed = 1'b0;

  pick_t       pending_picks[$];
  pick_t       mon_got;
  pick_t       mon_want;
  int unsigned fails = 0;
  int unsigned cand_cnt = 0;
  int unsigned pick_cnt = 0;
  int unsigned idle_cycles = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  bit          hold_req = 1'b0;

  logic [7:0] mask_plan [NumMasks] = '{8'd0, 8'd128, 8'd1, 8'd64, 8'd63, 8'd255, 8'd65,
                                       8'd127, 8'd129, 8'd126};

  stim_row_t dir_rows [NumRows] = '{
    '{'{GrpHi, GrpLo, 64'h2001_0DB8_0000_0000, 64'd1, 8'd5, 1'b0, 1'b1}, CHK_FIXED, NoPick},
    '{'{64'd0, 64'd0, 64'd0, 64'd0, 8'd0, 1'b0, 1'b1}, CHK_FIXED, NoPick},
    '{'{AllOnes, AllOnes, AllOnes, AllOnes, 8'd255, 1'b1, 1'b1}, CHK_PREDICT, NoPick},
    '{'{64'd0, 64'd0, 64'd0, 64'd0, 8'd0, 1'b1, 1'b1}, CHK_PREDICT, NoPick},
    '{'{GrpHi, GrpLo, 64'h2001_0DB8_0000_0001, 64'h10, 8'd3, 1'b1, 1'b0}, CHK_PREDICT, NoPick},
    '{'{64'd0, 64'd0, 64'h2001_0DB8_0000_0002, 64'h20, 8'd3, 1'b0, 1'b0}, CHK_PREDICT, NoPick},
    '{'{64'd0, 64'd0, 64'h2001_0DB8_0000_0003, 64'h30, 8'd3, 1'b0, 1'b0}, CHK_PREDICT, NoPick},
    '{'{64'd0, 64'd0, 64'h2001_0DB8_0000_0004, 64'h40, 8'd4, 1'b0, 1'b0}, CHK_PREDICT, NoPick},
    '{'{64'd0, 64'd0, 64'h2001_0DB8_0000_0005, 64'h50, 8'd3, 1'b0, 1'b0}, CHK_PREDICT, NoPick},
    '{'{64'd0, 64'd0, 64'h2001_0DB8_0000_0006, 64'h60, 8'd3, 1'b0, 1'b1}, CHK_PREDICT, NoPick},
    '{'{GrpHi, GrpLo, 64'h1111_1111_2222_2222, 64'd0, 8'd7, 1'b1, 1'b1}, CHK_PREDICT, NoPick},
    '{'{64'd0, 64'd0, 64'h2222_2222_1111_1111, 64'd0, 8'd7, 1'b0, 1'b1}, CHK_PREDICT, NoPick},
    '{'{GrpHi, GrpLo, 64'h2222_2222_1111_1111, 64'd0, 8'd9, 1'b1, 1'b0}, CHK_PREDICT, NoPick},
    '{'{64'd0, 64'd0, 64'h1111_1111_2222_2222, 64'd0, 8'd9, 1'b0, 1'b1}, CHK_PREDICT, NoPick},
    '{'{GrpHi, GrpLo, 64'd0, 64'h0000_0001_0000_0002, 8'd1, 1'b1, 1'b0}, CHK_PREDICT, NoPick},
    '{'{64'd0, 64'd0, 64'd0, 64'h0000_0002_0000_0001, 8'd1, 1'b0, 1'b1}, CHK_PREDICT, NoPick},
    '{'{AllOnes, AllOnes, 64'd0, 64'd0, 8'd255, 1'b1, 1'b0}, CHK_PREDICT, NoPick},
    '{'{64'd0, 64'd0, AllOnes, AllOnes, 8'd255, 1'b0, 1'b1}, CHK_PREDICT, NoPick},
    '{'{AllOnes, 64'd0, 64'h8000_0000_0000_0000, 64'd1, 8'd0, 1'b1, 1'b0}, CHK_PREDICT, NoPick},
    '{'{64'd0, 64'd0, AllOnes, AllOnes, 8'd1, 1'b0, 1'b1}, CHK_PREDICT, NoPick}
  };

  function automatic logic [31:0] fold_words(input logic [63:0] hi, input logic [63:0] lo);
    logic [31:0] x;
    logic [31:0] y;
    x = hi[63:32] ^ hi[31:0] ^ lo[63:32] ^ lo[31:0];
    y = {<<8{x}};
    return y;
  endfunction

  function automatic logic [30:0] rp_hash(input logic [31:0] g, input logic [31:0] c);
    logic [31:0] inner;
    logic [31:0] outer;
    inner = HashMul * g + HashAdd;
    outer = HashMul * (inner ^ c) + HashAdd;
    return outer[30:0];
  endfunction

  // Advances the selection by one candidate and returns whether it is the last candidate of the lookup.
  function automatic bit select_step(input cand_t c, output pick_t p);
    logic [7:0]   m;
    logic [127:0] keep;
    logic [30:0]  h;
    if (c.is_first) begin
      m = (sel_mask_len > MaskLenFull) ? MaskLenFull : sel_mask_len;
      keep = {c.g_hi, c.g_lo} & ({128{1'b1}} << (8'd128 - m));
      sel_grp_fold = fold_words(keep[127:64], keep[63:0]);
      sel_hash = rp_hash(sel_grp_fold, fold_words(c.r_hi, c.r_lo));
      sel_hi = c.r_hi;
      sel_lo = c.r_lo;
      sel_prio = c.prio;
      sel_closed = 1'b0;
    end else if (!sel_closed) begin
      if (c.prio != sel_prio) begin
        sel_closed = 1'b1;
      end else begin
        h = rp_hash(sel_grp_fold, fold_words(c.r_hi, c.r_lo));
        if (h > sel_hash || (h == sel_hash && {c.r_hi, c.r_lo} > {sel_hi, sel_lo})) begin
          sel_hash = h;
          sel_hi = c.r_hi;
          sel_lo = c.r_lo;
        end
      end
    end
    p = '{sel_hi, sel_lo, sel_prio, sel_hash};
    return c.is_last;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fails++;
    end
  endfunction

  task automatic send_cand(input cand_t c, input chk_e chk, input pick_t fixed);
    int unsigned gap;
    pick_t       want;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {c.prio, c.r_lo, c.r_hi, c.g_lo, c.g_hi};
    s_tuser <= c.is_first;
    s_tlast <= c.is_last;
    do @(posedge clk_i); while (!s_tready);
    cand_cnt++;
    if (select_step(c, want)) begin
      pending_picks.insert(pending_picks.size(), (chk == CHK_FIXED) ? fixed : want);
    end
  endtask

  // Candidates without tlast give no result, so the block may still be busy after the last result.
  task automatic settle();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mask_len(input logic [7:0] len);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sel_mask_len = len;
  endtask

  task automatic run_phase(input int unsigned n_items, input int unsigned pause_at);
    cand_t       c;
    int unsigned sent;
    int unsigned k;
    int unsigned pick;
    logic [7:0]  p;
    logic [63:0] gh;
    logic [63:0] gl;
    logic [63:0] prev_hi;
    logic [63:0] prev_lo;
    sent = 0;
    prev_hi = rand64();
    prev_lo = rand64();
    while (sent < n_items) begin
      k = $urandom_range(1, 6);
      pick = $urandom_range(0, 7);
      p = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 7);
      gh = (pick == 0) ? AllOnes : (pick == 1) ? 64'd0 : rand64();
      gl = (pick == 0) ? AllOnes : (pick == 1) ? 64'd0 : rand64();
      for (int i = 0; i < k; i++) begin
        pick = $urandom_range(0, 11);
        c.g_hi = (i == 0) ? gh : rand64();
        c.g_lo = (i == 0) ? gl : rand64();
        if (pick < 2) begin
          c.r_hi = {prev_hi[31:0], prev_hi[63:32]};
          c.r_lo = prev_lo;
        end else if (pick == 2) begin
          c.r_hi = AllOnes;
          c.r_lo = AllOnes;
        end else if (pick == 3) begin
          c.r_hi = 64'd0;
          c.r_lo = 64'd0;
        end else begin
          c.r_hi = rand64();
          c.r_lo = rand64();
        end
        prev_hi = c.r_hi;
        prev_lo = c.r_lo;
        c.prio = (i > 0 && $urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : p;
        c.is_first = (i == 0);
        c.is_last = (i == k - 1);
        if ($urandom_range(0, 9) == 0) begin
          c.is_first = 1'($urandom_range(0, 1));
          c.is_last = 1'($urandom_range(0, 1));
        end
        send_cand(c, CHK_PREDICT, NoPick);
        sent++;
        if (pause_at != 0 && sent == pause_at) begin
          settle();
        end
      end
    end
  endtask

  initial begin
    int unsigned rx_gap;
    int unsigned rx_hold;
    rx_gap = 0;
    rx_hold = 0;
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) begin
        rx_gap = rx_burst ? 0 : $urandom_range(0, 10);
      end
      @(negedge clk_i);
      if (hold_req) begin
        rx_hold = LongHold;
        hold_req = 1'b0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && m_tvalid && m_tready) begin
      pick_cnt++;
      mon_got = '{m_tdata[63:0], m_tdata[127:64], m_tdata[135:128], m_tdata[166:136]};
      if (pending_picks.size() == 0) begin
        $display("%0t: result transfer with nothing expected, expected none, got %h",
                 $time, m_tdata);
        fails++;
      end else begin
        mon_want = pending_picks.pop_front();
        check_field("chosen_rp_hi", mon_want.rp_hi, mon_got.rp_hi);
        check_field("chosen_rp_lo", mon_want.rp_lo, mon_got.rp_lo);
        check_field("chosen_priority", 64'(mon_want.prio), 64'(mon_got.prio));
        check_field("winning_hash", 64'(mon_want.hash), 64'(mon_got.hash));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      send_cand(dir_rows[i].cand, dir_rows[i].chk, dir_rows[i].fixed);
    end
    settle();

    for (int ph = 0; ph < NumMasks; ph++) begin
      write_mask_len(mask_plan[ph]);
      tx_burst = (ph % 3 == 1);
      rx_burst = tx_burst;
      // The receiver stalls for a long stretch while candidates keep coming.
      if (ph == 2) begin
        tx_burst = 1'b1;
        hold_req = 1'b1;
      end
      run_phase(PhaseItems, (ph == 5) ? PhaseItems / 2 : 0);
      settle();
    end

    $display("Covered %0d candidate transfers and %0d result transfers over %0d mask lengths,",
             cand_cnt, pick_cnt, NumMasks);
    $display("with priority cutoffs, address ties, unframed candidates and back-pressure.");
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[rp_hash_selection_top.f]
rtl/core/rphs_pkg.sv
rtl/core/rphs_group_mask.sv
rtl/core/rphs_hash_unit.sv
rtl/core/rp_hash_selection_top.sv
verif/rp_hash_selection_top_tb.sv
